[sv/bmp24_pkg.sv]
// Package for the 24-bit BMP stream decoder.
// Holds the channel word types, header byte positions, phase and status codes.
// No dependencies.
`timescale 1ns / 1ps

package bmp24_pkg;

    typedef struct packed {
        logic       start_of_file;
        logic [7:0] byte_value;
    } t_in_word;

    typedef struct packed {
        logic [23:0] dest_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [1:0]  status;
        logic        last;
    } t_out_word;

    // Verdict of the header checker for the current byte.
    typedef struct packed {
        logic       err;
        logic [1:0] code;
        logic       done;
    } t_hdr_chk;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_UNSUPP = 2'd2;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    localparam logic [1:0] LANE_BLUE  = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_RED   = 2'd2;

    // Header byte positions at which something is checked or captured.
    localparam logic [5:0] HP_SIZE   = 6'd0;
    localparam logic [5:0] HP_SIG    = 6'd1;
    localparam logic [5:0] HP_OFFSET = 6'd13;
    localparam logic [5:0] HP_WIDTH  = 6'd21;
    localparam logic [5:0] HP_HEIGHT = 6'd25;
    localparam logic [5:0] HP_GEOM   = 6'd26;
    localparam logic [5:0] HP_PROD   = 6'd27;
    localparam logic [5:0] HP_NEED   = 6'd28;
    localparam logic [5:0] HP_DEPTH  = 6'd29;
    localparam logic [5:0] HP_COMP   = 6'd33;

    localparam logic [15:0] SIG_BM      = 16'h4D42;
    localparam logic [31:0] MIN_FILE    = 32'd14;
    localparam logic [31:0] MIN_OFFSET  = 32'd54;
    localparam logic [15:0] DEPTH_BGR24 = 16'd24;

endpackage

[sv/bmp24_hdr.sv]
// Header parser and checker of the BMP decoder.
// Captures header fields, precomputes row padding and size checks over spare bytes.
// Depends on bmp24_pkg.
`timescale 1ns / 1ps

module bmp24_hdr import bmp24_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int W          = 13,
    parameter int H          = 13
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [5:0]    i_pos,
    input  logic [7:0]    i_byte,
    input  logic [31:0]   i_file_size,
    output t_hdr_chk      o_chk,
    output logic [31:0]   o_offset,
    output logic [W-1:0]  o_width,
    output logic [H-1:0]  o_height,
    output logic          o_flip,
    output logic [W+1:0]  o_pad,
    output logic [23:0]   o_start
);

    localparam int PRW = W + 2 + H;
    localparam int SW  = W + H;
    localparam int NW  = (PRW > 32 ? PRW : 32) + 1;

    logic [31:0]    r_scratch;
    logic [31:0]    r_offset;
    logic [31:0]    r_raw_w;
    logic [31:0]    r_raw_h;
    logic [15:0]    r_depth;
    logic [W+1:0]   r_pad;
    logic [H-1:0]   r_mag;
    logic           r_neg;
    logic           r_h_big;
    logic [PRW-1:0] r_prod;
    logic [23:0]    r_start;
    logic           r_big;

    logic [31:0]    w_scr;
    logic [31:0]    w_mag32;
    logic [W-1:0]   w_w;
    logic [W+1:0]   w_pad_sum;
    logic [SW-1:0]  w_start_prod;

    assign w_scr        = {i_byte, r_scratch[31:8]};
    assign w_mag32      = r_raw_h[31] ? (32'd0 - r_raw_h) : r_raw_h;
    assign w_w          = r_raw_w[W-1:0];
    assign w_pad_sum    = (W+2)'({w_w, 1'b0}) + (W+2)'(w_w) + (W+2)'(3);
    assign w_start_prod = SW'(r_mag - H'(1)) * SW'(w_w);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scratch <= w_scr;
            unique case (i_pos)
                HP_OFFSET: r_offset <= w_scr;
                HP_WIDTH:  r_raw_w  <= w_scr;
                HP_HEIGHT: r_raw_h  <= w_scr;
                HP_GEOM: begin
                    // Values only matter once the size limits pass, so the
                    // truncated width and height are exact where used.
                    r_pad   <= {w_pad_sum[W+1:2], 2'b00};
                    r_mag   <= w_mag32[H-1:0];
                    r_neg   <= r_raw_h[31];
                    r_h_big <= w_mag32 > 32'(MAX_HEIGHT);
                end
                HP_PROD:   r_prod   <= PRW'(r_pad) * PRW'(r_mag);
                HP_NEED: begin
                    r_big   <= (NW'(r_offset) + NW'(r_prod)) > NW'(i_file_size);
                    r_start <= 24'(w_start_prod);
                end
                HP_DEPTH:  r_depth  <= w_scr[31:16];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_chk = '{err: 1'b0, code: ST_OK, done: 1'b0};
        unique case (i_pos)
            HP_SIZE: begin
                if (i_file_size < MIN_FILE) o_chk = '{1'b1, ST_FORMAT, 1'b0};
            end
            HP_SIG: begin
                if (w_scr[31:16] != SIG_BM) o_chk = '{1'b1, ST_FORMAT, 1'b0};
            end
            HP_OFFSET: begin
                if (w_scr >= i_file_size || w_scr < MIN_OFFSET)
                    o_chk = '{1'b1, ST_FORMAT, 1'b0};
            end
            HP_COMP: begin
                if (w_scr != 32'd0)
                    o_chk = '{1'b1, ST_UNSUPP, 1'b0};
                else if (r_depth != DEPTH_BGR24)
                    o_chk = '{1'b1, ST_UNSUPP, 1'b0};
                else if (r_raw_w == 32'd0 || r_raw_w[31] || r_raw_h == 32'd0)
                    o_chk = '{1'b1, ST_FORMAT, 1'b0};
                else if (r_raw_w > 32'(MAX_WIDTH) || r_h_big)
                    o_chk = '{1'b1, ST_UNSUPP, 1'b0};
                else if (r_big)
                    o_chk = '{1'b1, ST_FORMAT, 1'b0};
                else
                    o_chk = '{1'b0, ST_OK, 1'b1};
            end
            default: ;
        endcase
    end

    assign o_offset = r_offset;
    assign o_width  = w_w;
    assign o_height = r_mag;
    assign o_flip   = !r_neg;
    assign o_pad    = r_pad;
    // Top-down images start at index zero; bottom-up ones at the last row.
    assign o_start  = r_neg ? 24'd0 : r_start;

endmodule

[sv/bmp24_pix.sv]
// Pixel unpacker of the BMP decoder.
// Gathers BGR triples, skips row padding and keeps the destination index.
// Depends on bmp24_pkg.
`timescale 1ns / 1ps

module bmp24_pix import bmp24_pkg::*; #(
    parameter int W = 13,
    parameter int H = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_en,
    input  logic [7:0]    i_byte,
    input  logic [W-1:0]  i_width,
    input  logic [H-1:0]  i_height,
    input  logic          i_flip,
    input  logic [W+1:0]  i_pad,
    input  logic [23:0]   i_start,
    output logic          o_valid,
    output t_out_word     o_word,
    output logic          o_fin
);

    localparam int RW = W + 2;

    logic [W-1:0]  r_col, n_col;
    logic [H-1:0]  r_row, n_row;
    logic [RW-1:0] r_rbc, n_rbc;
    logic [1:0]    r_lane, n_lane;
    logic [23:0]   r_idx, n_idx;
    logic [7:0]    r_blue;
    logic [7:0]    r_green;

    logic          w_in_px;
    logic          w_px;
    logic [RW-1:0] w_rbc_inc;
    logic          w_row_end;

    assign w_in_px   = r_col < i_width;
    assign w_px      = i_en && w_in_px && (r_lane == LANE_RED);
    assign w_rbc_inc = r_rbc + RW'(1);
    assign w_row_end = w_rbc_inc == i_pad;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_rbc  = w_rbc_inc;
        n_lane = r_lane;
        if (w_in_px) begin
            n_lane = (r_lane == LANE_RED) ? LANE_BLUE : r_lane + 2'd1;
        end
        if (w_px) begin
            n_col = r_col + W'(1);
        end
        if (w_row_end) begin
            n_rbc  = '0;
            n_col  = '0;
            n_row  = r_row + H'(1);
            n_lane = LANE_BLUE;
        end
        // Bottom-up: after a row the index has run one width past its start,
        // so stepping back two widths lands on the row above.
        n_idx = r_idx + (w_px ? 24'd1 : 24'd0)
              - ((w_row_end && i_flip) ? 24'({i_width, 1'b0}) : 24'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rbc  <= '0;
            r_lane <= LANE_BLUE;
            r_idx  <= '0;
        end else if (i_load) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rbc  <= '0;
            r_lane <= LANE_BLUE;
            r_idx  <= i_start;
        end else if (i_en) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_rbc  <= n_rbc;
            r_lane <= n_lane;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_in_px && r_lane == LANE_BLUE) r_blue <= i_byte;
        if (i_en && w_in_px && r_lane == LANE_GREEN) r_green <= i_byte;
    end

    assign o_fin   = w_px && (r_row == i_height - H'(1)) && (r_col == i_width - W'(1));
    assign o_valid = w_px;
    assign o_word  = '{dest_index: r_idx, red: i_byte, green: r_green, blue: r_blue,
                       status: ST_OK, last: o_fin};

endmodule

[sv/bmp24_stream_decoder.sv]
// Top level of the 24-bit BMP stream decoder.
// Instantiates bmp24_hdr and bmp24_pix; uses bmp24_pkg.
//
//   Channel   Direction  Handshake               Word
//   in        input      i_in_valid/o_in_stall   t_in_word, one file byte
//   out       output     o_out_valid/i_out_stall t_out_word, one pixel or status
//   cfg       input      i_cfg_wr_en             32-bit file size
//
// One byte is taken every cycle unless o_in_stall is high; its result, if any, is
// registered in the output register, or in the skid register when that one is stalled.
// A skid register behind the output register lets input continue for one
// result while the output is stalled; o_in_stall rises only when both are full.
// Reset is synchronous: file size goes to zero and the parser to the header.
`timescale 1ns / 1ps

module bmp24_stream_decoder import bmp24_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data
);

    localparam int W = $clog2(MAX_WIDTH + 1);
    localparam int H = $clog2(MAX_HEIGHT + 1);

    logic [31:0] r_file_size;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic        r_out_valid;
    t_out_word   r_out_word;
    logic        r_skid_valid;
    t_out_word   r_skid_word;

    logic        w_acc;
    logic        w_sof;
    logic [1:0]  w_phase;
    logic [31:0] w_pos;
    logic        w_hdr_en;
    logic        w_skip_hit;
    logic        w_pix_en;
    logic        w_take;
    logic        w_res_valid;
    t_out_word   w_res_word;

    t_hdr_chk    w_chk;
    logic [31:0] w_offset;
    logic [W-1:0] w_width;
    logic [H-1:0] w_height;
    logic        w_flip;
    logic [W+1:0] w_pad;
    logic [23:0] w_start;
    logic        w_px_valid;
    t_out_word   w_px_word;
    logic        w_px_fin;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_sof      = i_in_data.start_of_file;
    assign w_phase    = w_sof ? PH_HEADER : r_phase;
    assign w_pos      = w_sof ? 32'd0 : r_pos;
    assign w_hdr_en   = w_acc && (w_phase == PH_HEADER);
    assign w_skip_hit = (w_phase == PH_SKIP) && (r_pos == w_offset);
    assign w_pix_en   = w_acc && ((w_phase == PH_PIXELS) || w_skip_hit);

    bmp24_hdr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .W          (W),
        .H          (H)
    ) u_hdr (
        .i_clk       (i_clk),
        .i_en        (w_hdr_en),
        .i_pos       (w_pos[5:0]),
        .i_byte      (i_in_data.byte_value),
        .i_file_size (r_file_size),
        .o_chk       (w_chk),
        .o_offset    (w_offset),
        .o_width     (w_width),
        .o_height    (w_height),
        .o_flip      (w_flip),
        .o_pad       (w_pad),
        .o_start     (w_start)
    );

    bmp24_pix #(
        .W (W),
        .H (H)
    ) u_pix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_hdr_en && w_chk.done),
        .i_en     (w_pix_en),
        .i_byte   (i_in_data.byte_value),
        .i_width  (w_width),
        .i_height (w_height),
        .i_flip   (w_flip),
        .i_pad    (w_pad),
        .i_start  (w_start),
        .o_valid  (w_px_valid),
        .o_word   (w_px_word),
        .o_fin    (w_px_fin)
    );

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        if (w_acc) begin
            n_phase = w_phase;
            n_pos   = w_pos;
            unique case (w_phase)
                PH_HEADER: begin
                    n_pos = w_pos + 32'd1;
                    if (w_chk.err) n_phase = PH_HALT;
                    else if (w_chk.done) n_phase = PH_SKIP;
                end
                PH_SKIP: begin
                    if (!w_skip_hit) n_pos = r_pos + 32'd1;
                    else n_phase = w_px_fin ? PH_HALT : PH_PIXELS;
                end
                PH_PIXELS: begin
                    if (w_px_fin) n_phase = PH_HALT;
                end
                PH_HALT: ;
                default: ;
            endcase
        end
    end

    assign w_res_valid = (w_hdr_en && w_chk.err) || w_px_valid;
    assign w_res_word  = (w_hdr_en && w_chk.err)
                       ? '{dest_index: 24'd0, red: 8'd0, green: 8'd0, blue: 8'd0,
                           status: w_chk.code, last: 1'b1}
                       : w_px_word;

    assign w_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size  <= '0;
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_file_size <= i_cfg_wr_data;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (r_skid_valid) begin
                if (w_take) begin
                    r_out_word   <= r_skid_word;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_acc && w_res_valid) begin
                if (!r_out_valid || w_take) begin
                    r_out_word  <= w_res_word;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_word  <= w_res_word;
                    r_skid_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held while output register empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(i_out_stall))
        else $error("skid register filled without an output stall");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status != ST_OK) |-> r_out_word.last)
        else $error("error word without last");

    a_last_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_res_valid && w_res_word.last) |=> (r_phase == PH_HALT))
        else $error("parser did not halt after the final word");

    a_pixel_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_px_valid |-> (w_phase == PH_PIXELS || w_phase == PH_SKIP))
        else $error("pixel produced outside the pixel data");

endmodule

[test/bmp24_stream_decoder_test.sv]
// Self-checking testbench for bmp24_stream_decoder: streams BMP files a byte at a time
// and checks every pixel and status word against a behavioral decoder kept in step.
// Depends on bmp24_pkg and the decoder RTL.
`timescale 1ns / 1ps

module bmp24_stream_decoder_test;
    import bmp24_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BYTES  = 200;
    localparam int REPORT_LINES  = 40;
    // Enough bytes to reach every header check, plus a few that must be ignored.
    localparam int CHECK_BYTES   = 36;

    typedef enum int {SOF_NONE, SOF_FIRST, SOF_RANDOM} t_sof_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data     = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    t_out_word   o_out_data;

    t_in_word  file_bytes[$];
    t_out_word expected_pixels[$];
    bit [7:0]  file_buf[$];

    int bytes_queued, bytes_taken, files_sent, size_writes;
    int words_checked, pixels_checked, errors_checked, mismatches;
    int gap_left, stall_left, quiet;
    bit idle_on = 1'b1;

    // Decoder state as the block should hold it.
    bit [31:0]  dec_size, dec_pos, dec_offset, dec_width, dec_height, dec_scratch;
    bit [31:0]  dec_rows, dec_cols, dec_row_bytes, dec_raw_w, dec_raw_h, dec_depth;
    bit [31:0]  dec_padded;
    bit         dec_flip;
    bit [7:0]   dec_blue, dec_green;
    logic [1:0] dec_phase = PH_HEADER;

    bmp24_stream_decoder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic decode_byte(input t_in_word w);
        bit [31:0]  at, mag, pad, lane, dest;
        bit [63:0]  need;
        bit         fin;
        logic [1:0] code;
        t_out_word  r;
        r    = '0;
        code = ST_OK;
        if (w.start_of_file) begin
            dec_pos    = 0; dec_offset = 0; dec_width = 0; dec_height = 0;
            dec_flip   = 0; dec_scratch = 0; dec_rows = 0; dec_cols = 0;
            dec_row_bytes = 0; dec_blue = 0; dec_green = 0; dec_raw_w = 0;
            dec_raw_h  = 0; dec_depth = 0; dec_padded = 0;
            dec_phase  = PH_HEADER;
        end
        if (dec_phase == PH_HEADER) begin
            at          = dec_pos;
            dec_scratch = {w.byte_value, dec_scratch[31:8]};
            dec_pos     = at + 1;
            if (at == HP_SIZE && dec_size < MIN_FILE) code = ST_FORMAT;
            if (at == HP_SIG && dec_scratch[31:16] != SIG_BM) code = ST_FORMAT;
            if (at == HP_OFFSET) begin
                dec_offset = dec_scratch;
                if (dec_offset >= dec_size || dec_offset < MIN_OFFSET) code = ST_FORMAT;
            end
            if (at == HP_WIDTH) dec_raw_w = dec_scratch;
            if (at == HP_HEIGHT) dec_raw_h = dec_scratch;
            if (at == HP_DEPTH) dec_depth = {16'd0, dec_scratch[31:16]};
            if (at == HP_COMP) begin
                mag  = dec_raw_h[31] ? -dec_raw_h : dec_raw_h;
                pad  = (dec_raw_w * 3 + 3) & ~32'd3;
                need = 64'(dec_offset) + 64'(pad) * 64'(mag);
                if (dec_scratch != 0)
                    code = ST_UNSUPP;
                else if (dec_depth != DEPTH_BGR24)
                    code = ST_UNSUPP;
                else if (dec_raw_w == 0 || dec_raw_w[31] || dec_raw_h == 0)
                    code = ST_FORMAT;
                else if (dec_raw_w > MAX_W || mag > MAX_H)
                    code = ST_UNSUPP;
                else if (need > 64'(dec_size))
                    code = ST_FORMAT;
                else begin
                    dec_width  = dec_raw_w;
                    dec_height = mag;
                    dec_padded = pad;
                    // A positive height means the rows arrive bottom row first.
                    dec_flip   = !dec_raw_h[31];
                    dec_phase  = PH_SKIP;
                end
            end
            if (code != ST_OK) begin
                r.status  = code;
                r.last    = 1'b1;
                dec_phase = PH_HALT;
                expected_pixels.push_back(r);
            end
        end else if (dec_phase == PH_SKIP && dec_pos != dec_offset) begin
            dec_pos = dec_pos + 1;
        end else if (dec_phase != PH_HALT) begin
            dec_phase = PH_PIXELS;
            if (dec_row_bytes < dec_width * 3) begin
                lane = dec_row_bytes - dec_cols * 3;
                if (lane == LANE_BLUE) begin
                    dec_blue = w.byte_value;
                end else if (lane == LANE_GREEN) begin
                    dec_green = w.byte_value;
                end else begin
                    dest = dec_flip ? dec_height - 1 - dec_rows : dec_rows;
                    fin  = (dec_rows == dec_height - 1) && (dec_cols == dec_width - 1);
                    r.dest_index = 24'(dest * dec_width + dec_cols);
                    r.red    = w.byte_value;
                    r.green  = dec_green;
                    r.blue   = dec_blue;
                    r.status = ST_OK;
                    r.last   = fin;
                    expected_pixels.push_back(r);
                    dec_cols = dec_cols + 1;
                    if (fin) dec_phase = PH_HALT;
                end
            end
            if (dec_phase != PH_HALT) begin
                dec_row_bytes = dec_row_bytes + 1;
                if (dec_row_bytes >= dec_padded) begin
                    dec_row_bytes = 0;
                    dec_cols      = 0;
                    dec_rows      = dec_rows + 1;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < REPORT_LINES)
            $display("mismatch at output word %0d, %s: got 0x%0h, expected 0x%0h",
                     words_checked, what, got, want);
        mismatches++;
    endtask

    task automatic put_le(input bit [31:0] v, input int n);
        for (int k = 0; k < n; k++) file_buf.push_back(v[8*k +: 8]);
    endtask

    // Builds a file in file_buf; with rows at zero only the headers are built.
    task automatic build_bmp(input bit [31:0] w, input bit [31:0] h, input bit [31:0] off,
                             input bit [15:0] bpp, input bit [31:0] comp,
                             input bit [15:0] sig, input int rows);
        int row_len;
        file_buf.delete();
        put_le(32'(sig), 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le(off, 4);
        put_le(40, 4);
        put_le(w, 4);
        put_le(h, 4);
        put_le(1, 2);
        put_le(32'(bpp), 2);
        put_le(comp, 4);
        while (file_buf.size() < MIN_OFFSET || (rows > 0 && file_buf.size() < off))
            file_buf.push_back(8'($urandom));
        row_len = ((w * 3 + 3) / 4) * 4;
        repeat (rows * row_len) file_buf.push_back(8'($urandom));
    endtask

    task automatic push_bytes(input int from, input int upto, input t_sof_mode mode);
        t_in_word b;
        for (int k = from; k < upto && k < file_buf.size(); k++) begin
            b.byte_value    = file_buf[k];
            b.start_of_file = (mode == SOF_RANDOM) ? ($urandom_range(0, 3) == 0)
                                                   : (mode == SOF_FIRST && k == 0);
            file_bytes.push_back(b);
            bytes_queued++;
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (bytes_taken != bytes_queued || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input bit [31:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dec_size = v;
        size_writes++;
    endtask

    // The file size is only changed once the decoder has gone quiet.
    task automatic send_file(input bit [31:0] size, input t_sof_mode mode, input int upto);
        if (size != dec_size || size_writes == 0) begin
            wait_idle();
            write_size(size);
        end
        push_bytes(0, upto, mode);
        files_sent++;
    endtask

    always @(posedge i_clk) begin : drive_bytes
        bit taken;
        taken = i_in_valid && !o_in_stall;
        if (taken) begin
            decode_byte(i_in_data);
            bytes_taken++;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (taken || !i_in_valid) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (file_bytes.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= $urandom_range(0, 2);
            end else begin
                i_in_data  <= file_bytes.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("word with nothing expected", 64'(o_out_data), 64'd0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.dest_index !== want.dest_index)
                    report_mismatch("dest_index", 64'(o_out_data.dest_index),
                                    64'(want.dest_index));
                if (o_out_data.red !== want.red)
                    report_mismatch("red", 64'(o_out_data.red), 64'(want.red));
                if (o_out_data.green !== want.green)
                    report_mismatch("green", 64'(o_out_data.green), 64'(want.green));
                if (o_out_data.blue !== want.blue)
                    report_mismatch("blue", 64'(o_out_data.blue), 64'(want.blue));
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                if (o_out_data.last !== want.last)
                    report_mismatch("last", 64'(o_out_data.last), 64'(want.last));
                if (want.status == ST_OK) pixels_checked++;
                else errors_checked++;
            end
            words_checked++;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", QUIET_LIMIT);
            $display("bmp24_stream_decoder regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        bit [31:0] w, h, off, size, mag;
        int        kind, at, start_count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first file after reset comes without a start marker.
        build_bmp(2, 2, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 2);
        send_file(file_buf.size(), SOF_NONE, file_buf.size());

        // Top-down image with row padding and a gap before the pixel data.
        build_bmp(3, -3, MIN_OFFSET + 3, DEPTH_BGR24, 0, SIG_BM, 3);
        send_file(file_buf.size(), SOF_FIRST, file_buf.size());

        // Short files; the rest of each file is ignored after the error.
        build_bmp(1, 1, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 1);
        send_file(0, SOF_FIRST, 20);
        send_file(MIN_FILE - 1, SOF_FIRST, 20);
        send_file(MIN_FILE, SOF_FIRST, 20);

        // Bad signatures.
        build_bmp(1, 1, MIN_OFFSET, DEPTH_BGR24, 0, 16'h4E42, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(1, 1, MIN_OFFSET, DEPTH_BGR24, 0, 16'h4D41, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);

        // Offsets inside the headers and at the end of the file.
        build_bmp(1, 1, MIN_OFFSET - 1, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(1, 1, 100, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(100, SOF_FIRST, CHECK_BYTES);

        // Compression, depth, dimensions, size limits.
        build_bmp(1, 1, MIN_OFFSET, DEPTH_BGR24, 1, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(1, 1, MIN_OFFSET, 32, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(0, 1, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(-1, 1, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(1, 0, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(MAX_W + 1, 1, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(1, MAX_H + 1, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);
        build_bmp(1, -(MAX_H + 1), MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 0);
        send_file(200, SOF_FIRST, CHECK_BYTES);

        // Pixel data one byte longer than the file allows.
        build_bmp(4, 2, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 2);
        send_file(file_buf.size() - 1, SOF_FIRST, file_buf.size());

        // The sender holds off in the middle of an image until every word is out.
        build_bmp(5, 3, MIN_OFFSET + 2, DEPTH_BGR24, 0, SIG_BM, 3);
        send_file(file_buf.size(), SOF_FIRST, 70);
        wait_idle();
        push_bytes(70, file_buf.size(), SOF_FIRST);

        // Largest file size; a file cut short is restarted by the next one.
        build_bmp(2, 2, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 2);
        send_file(32'hFFFF_FFFF, SOF_FIRST, 60);
        send_file(32'hFFFF_FFFF, SOF_FIRST, file_buf.size());

        // Largest width and largest height; each file stops after two pixels.
        build_bmp(MAX_W, 1, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, 1);
        send_file(file_buf.size(), SOF_FIRST, MIN_OFFSET + 6);
        build_bmp(2, MAX_H, MIN_OFFSET, DEPTH_BGR24, 0, SIG_BM, MAX_H);
        send_file(file_buf.size(), SOF_FIRST, MIN_OFFSET + 6);

        start_count = bytes_queued;
        while (bytes_queued - start_count < RANDOM_BYTES) begin
            if (bytes_queued - start_count > RANDOM_BYTES * 3 / 4) idle_on = 1'b0;
            kind = $urandom_range(0, 9);
            w    = $urandom_range(1, 5);
            mag  = $urandom_range(1, 3);
            h    = $urandom_range(0, 1) ? mag : -mag;
            off  = MIN_OFFSET + $urandom_range(0, 4);
            build_bmp(w, h, off, DEPTH_BGR24, 0, SIG_BM, mag);
            case (kind)
                0, 1, 2, 3: begin
                    size = file_buf.size();
                    case ($urandom_range(0, 3))
                        2: size = size + $urandom_range(1, 300);
                        3: size = 32'hFFFF_FFFF;
                        default: ;
                    endcase
                    send_file(size, SOF_FIRST, file_buf.size());
                end
                4: send_file(file_buf.size(), SOF_FIRST,
                             $urandom_range(35, file_buf.size() - 1));
                5: send_file(file_buf.size() - $urandom_range(1, 3), SOF_FIRST,
                             file_buf.size());
                6: begin
                    case ($urandom_range(0, 5))
                        0: at = $urandom_range(0, 1);
                        1: at = $urandom_range(10, 13);
                        2: at = $urandom_range(18, 21);
                        3: at = $urandom_range(22, 25);
                        4: at = $urandom_range(28, 29);
                        default: at = $urandom_range(30, 33);
                    endcase
                    file_buf[at] = 8'($urandom);
                    send_file($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(55, 300),
                              SOF_FIRST, $urandom_range(at + 1, MIN_OFFSET));
                end
                7: begin
                    w   = $urandom_range(0, 1) ? $urandom_range(MAX_W - 2, MAX_W + 2) : 1;
                    mag = $urandom_range(MAX_H - 2, MAX_H + 2);
                    build_bmp(w, $urandom_range(0, 1) ? mag : -mag, MIN_OFFSET,
                              DEPTH_BGR24, 0, SIG_BM, 0);
                    send_file(32'hFFFF_FFFF, SOF_FIRST, 40);
                end
                8: begin
                    file_buf.delete();
                    repeat ($urandom_range(1, 30)) file_buf.push_back(8'($urandom));
                    send_file($urandom_range(0, 1) ? $urandom : $urandom_range(0, 20),
                              SOF_RANDOM, file_buf.size());
                end
                default: send_file(file_buf.size(), SOF_NONE, file_buf.size());
            endcase
        end

        wait_idle();
        $display("streamed %0d files, %0d bytes, under %0d file size settings",
                 files_sent, bytes_queued, size_writes);
        $display("checked %0d pixel words and %0d status words", pixels_checked, errors_checked);
        if (mismatches == 0) begin
            $display("bmp24_stream_decoder regression: pass");
        end else begin
            $display("bmp24_stream_decoder regression: fail");
        end
        $finish;
    end

endmodule
